### rtl/ufsc_pkg.sv
// Package with the shared constants, payload types and control structs of the spanning cost unit.
package ufsc_pkg;

    localparam int NODE_COUNT = 256;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int HEIGHT_W   = 4;
    localparam int COST_W     = 24;
    localparam int EDGE_W     = 16;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
    localparam logic [COST_W-1:0]   COST_MAX   = '1;

    typedef struct packed {
        logic              action;
        logic [7:0]        node_a;
        logic [7:0]        node_b;
        logic [EDGE_W-1:0] edge_cost;
    } item_t;

    typedef struct packed {
        logic              joined;
        logic [COST_W-1:0] total_cost;
    } result_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_NODE_A,
        RD_NODE_B,
        RD_PARENT
    } rd_sel_t;

    typedef struct packed {
        logic    clear;
        logic    load_item;
        rd_sel_t rd_sel;
        logic    take_ra;
        logic    take_rb;
        logic    merge;
        logic    skip;
        logic    push;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic at_root;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/ufsc_ctrl.sv
// Controller state machine that sequences the root walks, the join and the result transfer.
module ufsc_ctrl
    import ufsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK_A,
        S_WALK_B,
        S_JOIN,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        item_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (status.in_range)
                begin
                    cmd.rd_sel = RD_NODE_A;
                    state_next = S_WALK_A;
                end
                else
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_WALK_A:
            begin
                if (status.at_root)
                begin
                    cmd.take_ra = 1'b1;
                    cmd.rd_sel  = RD_NODE_B;
                    state_next  = S_WALK_B;
                end
                else
                begin
                    cmd.rd_sel = RD_PARENT;
                end
            end
            S_WALK_B:
            begin
                if (status.at_root)
                begin
                    cmd.take_rb = 1'b1;
                    state_next  = S_JOIN;
                end
                else
                begin
                    cmd.rd_sel = RD_PARENT;
                end
            end
            S_JOIN:
            begin
                cmd.merge  = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ufsc_dpath.sv
// Datapath with the parent and height memories, the walk registers, the total and the result.
module ufsc_dpath
    import ufsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    logic [NODE_W-1:0]   parent_mem [NODE_COUNT];
    logic [HEIGHT_W-1:0] height_mem [NODE_COUNT];

    logic [NODE_W-1:0]   parent_rd_reg;
    logic [HEIGHT_W-1:0] height_rd_reg;
    logic [NODE_W-1:0]   clr_addr_reg;

    item_t               item_reg;
    logic [NODE_W-1:0]   cur_reg;
    logic [NODE_W-1:0]   ra_reg;
    logic [NODE_W-1:0]   rb_reg;
    logic [HEIGHT_W-1:0] ha_reg;
    logic [HEIGHT_W-1:0] hb_reg;
    logic                joined_reg;
    logic [COST_W-1:0]   cost_sum_reg;
    logic [COST_W-1:0]   cost_sum_next;
    result_t             result_reg;
    logic                result_valid_reg;

    logic [NODE_W-1:0]   rd_addr;
    logic [NODE_W-1:0]   up_node;
    logic [HEIGHT_W-1:0] cur_height;
    logic                differ;
    logic                swap;
    logic [NODE_W-1:0]   lo_root;
    logic [NODE_W-1:0]   hi_root;
    logic [HEIGHT_W-1:0] lo_height;
    logic [HEIGHT_W-1:0] hi_height;
    logic [HEIGHT_W-1:0] inc_height;
    logic [HEIGHT_W-1:0] hi_height_new;
    logic                do_join;
    logic [COST_W:0]     sum_wide;

    assign up_node    = parent_rd_reg;
    assign cur_height = height_rd_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NODE_A: rd_addr = NODE_W'(item_reg.node_a);
            RD_NODE_B: rd_addr = NODE_W'(item_reg.node_b);
            RD_PARENT: rd_addr = up_node;
            default:   rd_addr = cur_reg;
        endcase
    end

    assign differ        = (ra_reg != rb_reg);
    assign swap          = (ha_reg > hb_reg);
    assign lo_root       = swap ? rb_reg : ra_reg;
    assign hi_root       = swap ? ra_reg : rb_reg;
    assign lo_height     = swap ? hb_reg : ha_reg;
    assign hi_height     = swap ? ha_reg : hb_reg;
    assign inc_height    = (lo_height == HEIGHT_MAX) ? HEIGHT_MAX : lo_height + 1'b1;
    assign hi_height_new = (inc_height > hi_height) ? inc_height : hi_height;
    assign do_join       = cmd.merge && differ;

    assign sum_wide      = {1'b0, cost_sum_reg} + (COST_W + 1)'(item_reg.edge_cost);
    assign cost_sum_next = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];

    assign status.clear_last = (clr_addr_reg == NODE_W'(NODE_COUNT - 1));
    assign status.in_range   = (int'(item_reg.node_a) < NODE_COUNT)
                            && (int'(item_reg.node_b) < NODE_COUNT);
    assign status.at_root    = (up_node == cur_reg);
    assign status.out_free   = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            parent_mem[clr_addr_reg] <= clr_addr_reg;
            height_mem[clr_addr_reg] <= '0;
        end
        else if (do_join)
        begin
            parent_mem[lo_root] <= hi_root;
            height_mem[hi_root] <= hi_height_new;
        end
        parent_rd_reg <= parent_mem[rd_addr];
        height_rd_reg <= height_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            cost_sum_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (do_join && item_reg.action)
            begin
                cost_sum_reg <= cost_sum_next;
            end
            if (cmd.push)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.rd_sel != RD_NONE)
        begin
            cur_reg <= rd_addr;
        end
        if (cmd.take_ra)
        begin
            ra_reg <= cur_reg;
            ha_reg <= cur_height;
        end
        if (cmd.take_rb)
        begin
            rb_reg <= cur_reg;
            hb_reg <= cur_height;
        end
        if (cmd.merge)
        begin
            joined_reg <= differ;
        end
        else if (cmd.skip)
        begin
            joined_reg <= 1'b0;
        end
        if (cmd.push)
        begin
            result_reg.joined     <= joined_reg;
            result_reg.total_cost <= cost_sum_reg;
        end
    end

endmodule

### rtl/union_find_spanning_cost_unit.sv
// Top level of the union-find spanning cost unit.
// For each item the two root walks follow the parent links of node_a and node_b up to their roots,
// reading the parent memory once per step through its single read port; then the join state
// writes the join and the push state loads the result register once the output register is free.
// With union by height a parent-link depth is at most log2(NODE_COUNT). One item is
// worked on at a time, and the next item is taken while a finished result still waits in the
// output register. After reset a clearing pass over all NODE_COUNT (256) entries writes every
// parent entry with its own index and every height with zero; item_ready stays low until it ends.
module union_find_spanning_cost_unit
    import ufsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ufsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ufsc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### rtl/ufsc_checker.sv
// Port-level checker for the spanning cost unit and the bind that attaches it to the top level.
module ufsc_checker
    import ufsc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("Result valid dropped before its transfer.");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable(result))
        else $error("Result payload changed while stalled.");

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("Unit took a second item right after an input transfer.");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !$rose(result_valid))
        else $error("Result appeared one cycle after an input transfer.");

endmodule

bind union_find_spanning_cost_unit ufsc_checker u_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for the union-find spanning cost unit.
module tb_top
    import ufsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_FREE    = 1'b0;
    localparam logic ACT_OFFERED = 1'b1;

    localparam int RANDOM_LINKS = 1460;
    localparam int TAIL_LINKS   = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    logic [NODE_W-1:0]   link_up [NODE_COUNT];
    logic [HEIGHT_W-1:0] set_height [NODE_COUNT];
    logic [COST_W-1:0]   run_total;
    result_t             outcomes_due[$];
    int                  errors      = 0;
    bit                  gaps_on     = 1'b1;
    bit                  hold_asked  = 1'b0;

    union_find_spanning_cost_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] cur;
        cur = node;
        for (int s = 0; s < NODE_COUNT; s++)
        begin
            if (link_up[cur] == cur)
                break;
            cur = link_up[cur];
        end
        return cur;
    endfunction

    function automatic result_t merge_sets(item_t it);
        logic [NODE_W-1:0]   ra;
        logic [NODE_W-1:0]   rb;
        logic [NODE_W-1:0]   swap;
        logic [HEIGHT_W:0]   grown;
        logic [COST_W:0]     sum;
        result_t             r;
        r.joined = 1'b0;
        if (int'(it.node_a) < NODE_COUNT && int'(it.node_b) < NODE_COUNT)
        begin
            ra = find_root(it.node_a);
            rb = find_root(it.node_b);
            if (ra != rb)
            begin
                if (set_height[ra] > set_height[rb])
                begin
                    swap = ra;
                    ra   = rb;
                    rb   = swap;
                end
                grown = set_height[ra] + 1'b1;
                if (grown > HEIGHT_MAX)
                    grown = HEIGHT_MAX;
                if (grown > set_height[rb])
                    set_height[rb] = grown[HEIGHT_W-1:0];
                link_up[ra] = rb;
                r.joined = 1'b1;
                if (it.action == ACT_OFFERED)
                begin
                    sum = run_total + it.edge_cost;
                    run_total = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
                end
            end
        end
        r.total_cost = run_total;
        return r;
    endfunction

    function automatic item_t make_link(logic act, logic [7:0] a, logic [7:0] b,
                                        logic [EDGE_W-1:0] cost);
        item_t it;
        it.action    = act;
        it.node_a    = a;
        it.node_b    = b;
        it.edge_cost = cost;
        return it;
    endfunction

    function automatic item_t random_link(int idx, int count);
        int         level;
        int         span;
        logic [7:0] a;
        logic [7:0] b;
        logic [EDGE_W-1:0] cost;
        level = (idx * 8) / count;
        span  = 1 << (level + 1);
        a = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            b = 8'($urandom_range(0, 255));
        else
            b = 8'((int'(a) & ~(span - 1)) | $urandom_range(0, span - 1));
        case ($urandom_range(0, 3))
            0: cost = '1;
            1: cost = EDGE_W'($urandom_range(0, 15));
            default: cost = EDGE_W'($urandom);
        endcase
        return make_link(($urandom_range(0, 3) == 0) ? ACT_FREE : ACT_OFFERED, a, b, cost);
    endfunction

    task automatic offer_link(input item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        outcomes_due.push_back(merge_sets(it));
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_done;
        result_t due;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, got joined %0d total %0d",
                             $time, result.joined, result.total_cost);
                    errors++;
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    if (result.joined !== due.joined)
                    begin
                        $display("%0t: joined mismatch, expected %0d got %0d",
                                 $time, due.joined, result.joined);
                        errors++;
                    end
                    if (result.total_cost !== due.total_cost)
                    begin
                        $display("%0t: total_cost mismatch, expected %0d got %0d",
                                 $time, due.total_cost, result.total_cost);
                        errors++;
                    end
                end
            end
            if (hold_asked && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        offer_link(make_link(ACT_FREE,    8'd0,   8'd0,   16'hFFFF));
        offer_link(make_link(ACT_OFFERED, 8'd0,   8'd1,   16'hFFFF));
        offer_link(make_link(ACT_OFFERED, 8'd1,   8'd0,   16'd5));
        offer_link(make_link(ACT_FREE,    8'd2,   8'd3,   16'hFFFF));
        offer_link(make_link(ACT_OFFERED, 8'd0,   8'd2,   16'd0));
        offer_link(make_link(ACT_OFFERED, 8'd255, 8'd254, 16'hAAAA));
        offer_link(make_link(ACT_OFFERED, 8'd3,   8'd255, 16'h5555));
        offer_link(make_link(ACT_FREE,    8'd252, 8'd253, 16'h1234));
        offer_link(make_link(ACT_OFFERED, 8'd128, 8'd127, 16'h8000));
        offer_link(make_link(ACT_OFFERED, 8'd252, 8'd128, 16'd1));
        offer_link(make_link(ACT_OFFERED, 8'd127, 8'd0,   16'h7FFF));
        offer_link(make_link(ACT_FREE,    8'd255, 8'd252, 16'hFFFF));
        offer_link(make_link(ACT_OFFERED, 8'd255, 8'd255, 16'hFFFF));
        offer_link(make_link(ACT_OFFERED, 8'd4,   8'd0,   16'h00FF));
        offer_link(make_link(ACT_OFFERED, 8'd0,   8'd5,   16'hFF00));
        offer_link(make_link(ACT_FREE,    8'd6,   8'd128, 16'h0F0F));
    endtask

    task automatic test_backpressure();
        hold_asked = 1'b1;
        for (int i = 0; i < 24; i++)
            offer_link(random_link(0, 1));
    endtask

    task automatic test_random_links();
        for (int i = 0; i < RANDOM_LINKS; i++)
            offer_link(random_link(i, RANDOM_LINKS));
    endtask

    task automatic test_quiet_tail();
        gaps_on = 1'b0;
        for (int i = 0; i < TAIL_LINKS; i++)
            offer_link(random_link(TAIL_LINKS / 2 + i / 2, TAIL_LINKS));
    endtask

    initial
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            link_up[i]    = NODE_W'(i);
            set_height[i] = '0;
        end
        run_total = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_links();
        test_quiet_tail();
        item_valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outcomes_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### union_find_spanning_cost_unit.f
rtl/ufsc_pkg.sv
rtl/ufsc_ctrl.sv
rtl/ufsc_dpath.sv
rtl/union_find_spanning_cost_unit.sv
rtl/ufsc_checker.sv
dv/tb_top.sv
